### sv/qiqws_pkg.sv
// Package for the quarter-rate I/Q window sum block.
// Holds field widths, command codes and sample-phase codes.
// No dependencies.
package qiqws_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W = 17;
   localparam int SUM_W = 23;
   localparam int DEFAULT_WINDOW_DEPTH = 64;

   // Command codes on the op field
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Position of a sample inside its group of four
   localparam logic [1:0] PHASE_S0 = 2'd0;
   localparam logic [1:0] PHASE_S1 = 2'd1;
   localparam logic [1:0] PHASE_S2 = 2'd2;
   localparam logic [1:0] PHASE_S3 = 2'd3;

endpackage

### sv/quarter_rate_iq_window_sum.sv
// Quarter-rate I/Q window sum: pairs of sin/cos differences in a sliding window
// kept in one synchronous RAM, with running totals. Uses qiqws_pkg.
//
// Channel   Dir  Ports                              Transaction
// req       in   req_valid req_stall req_op req_sample   one sample or a clear command
// rsp       out  rsp_valid rsp_stall rsp_sin_sum rsp_cos_sum  both window sums
//
// One request transaction is taken per cycle while req_stall is low. The fourth sample
// of a group reads the window RAM at the write pointer into a read register; when the
// update stage retires, the totals are updated, the slot is rewritten and the result
// is loaded into the output register.
// Reset is synchronous and clears phase, pointer, totals and the window-filled flag;
// RAM slots not yet written since reset or clear read as zero through that flag,
// so no clearing pass is needed.
// req_stall rises only while a finished group waits for a stalled output register.
module quarter_rate_iq_window_sum #(
   parameter int WINDOW_DEPTH = qiqws_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic signed [qiqws_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [qiqws_pkg::SUM_W-1:0]    rsp_sin_sum,
   output logic signed [qiqws_pkg::SUM_W-1:0]    rsp_cos_sum
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int DW = qiqws_pkg::DIFF_W;
   localparam int SW = qiqws_pkg::SUM_W;
   localparam int MEM_W = 2 * DW;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

   // Window RAM: {sin difference, cos difference} per slot
   logic [MEM_W-1:0] win_mem [WINDOW_DEPTH];
   logic [MEM_W-1:0] rd_data_ff;

   logic [1:0] phase_ff, phase_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic full_ff, full_in;
   logic signed [qiqws_pkg::SAMPLE_W-1:0] s0_ff, s1_ff, s2_ff;

   // Update stage, waiting on the RAM read
   logic s1_valid_ff, s1_valid_in;
   logic s1_old_ok_ff;
   logic [PTR_W-1:0] s1_slot_ff;
   logic signed [DW-1:0] s1_dsin_ff, s1_dcos_ff;

   logic signed [SW-1:0] sin_tot_ff, sin_tot_in;
   logic signed [SW-1:0] cos_tot_ff, cos_tot_in;
   logic signed [SW-1:0] sin_new, cos_new;
   logic signed [DW-1:0] old_sin, old_cos;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_sin_ff, rsp_cos_ff;

   logic req_take, is_clear, is_last, s1_go;
   logic signed [DW-1:0] dsin, dcos;

   // The update stage may retire whenever the output register is free or leaving
   assign s1_go = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take = req_valid && !req_stall;
   assign is_clear = req_take && (req_op == qiqws_pkg::OP_CLEAR);
   assign is_last = req_take && (req_op == qiqws_pkg::OP_SAMPLE)
                    && (phase_ff == qiqws_pkg::PHASE_S3);

   // 17-bit differences, no wrap
   assign dsin = DW'(s1_ff) - DW'(req_sample);
   assign dcos = DW'(s0_ff) - DW'(s2_ff);

   // Slots not written since the last clear read as zero
   assign old_sin = s1_old_ok_ff ? rd_data_ff[MEM_W-1:DW] : '0;
   assign old_cos = s1_old_ok_ff ? rd_data_ff[DW-1:0] : '0;
   assign sin_new = sin_tot_ff + SW'(s1_dsin_ff) - SW'(old_sin);
   assign cos_new = cos_tot_ff + SW'(s1_dcos_ff) - SW'(old_cos);

   always_comb begin
      phase_in = phase_ff;
      ptr_in = ptr_ff;
      full_in = full_ff;
      if (is_clear) begin
         phase_in = qiqws_pkg::PHASE_S0;
         ptr_in = '0;
         full_in = 1'b0;
      end else if (req_take) begin
         phase_in = phase_ff + 2'd1;
         if (is_last) begin
            // advance the pointer, wrapping at the window depth
            if (ptr_ff == PTR_LAST) begin
               ptr_in = '0;
               full_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
      end
   end

   always_comb begin
      sin_tot_in = sin_tot_ff;
      cos_tot_in = cos_tot_ff;
      if (is_clear) begin
         // a clear in the retire cycle lands after the update
         sin_tot_in = '0;
         cos_tot_in = '0;
      end else if (s1_go) begin
         sin_tot_in = sin_new;
         cos_tot_in = cos_new;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (is_last) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qiqws_pkg::PHASE_S0;
         ptr_ff <= '0;
         full_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         sin_tot_ff <= '0;
         cos_tot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ptr_ff <= ptr_in;
         full_ff <= full_in;
         s1_valid_ff <= s1_valid_in;
         sin_tot_ff <= sin_tot_in;
         cos_tot_ff <= cos_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the first three samples of the group
   always_ff @(posedge clock) begin
      if (req_take && (req_op == qiqws_pkg::OP_SAMPLE)) begin
         case (phase_ff)
            qiqws_pkg::PHASE_S0: s0_ff <= req_sample;
            qiqws_pkg::PHASE_S1: s1_ff <= req_sample;
            qiqws_pkg::PHASE_S2: s2_ff <= req_sample;
            default: ;
         endcase
      end
   end

   // Capture the update-stage payload
   always_ff @(posedge clock) begin
      if (is_last) begin
         s1_dsin_ff <= dsin;
         s1_dcos_ff <= dcos;
         s1_slot_ff <= ptr_ff;
         s1_old_ok_ff <= full_ff;
      end
   end

   // Window RAM: read on the fourth sample, write back on retire
   always_ff @(posedge clock) begin
      if (is_last) begin
         rd_data_ff <= win_mem[ptr_ff];
      end
      if (s1_go) begin
         win_mem[s1_slot_ff] <= {s1_dsin_ff, s1_dcos_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_sin_ff <= sin_new;
         rsp_cos_ff <= cos_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sin_sum = rsp_sin_ff;
   assign rsp_cos_sum = rsp_cos_ff;

endmodule
